/* rtl/ilir_pkg.sv */
// Shared types and constants for the indexed list block.
// No dependencies; imported by ilir_cell and indexed_list_insert_remove.
package ilir_pkg;

    // list geometry, fixed by the 5-bit index and count fields
    localparam int unsigned CAPACITY = 16;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned POSB_W   = 4;
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned STAT_W   = 2;

    // stream word widths
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned IN_USER_W  = 8;
    localparam int unsigned OUT_DATA_W = 40;

    // request kinds; 6 and 7 are ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_SET    = 3'd2,
        KIND_GET    = 3'd3,
        KIND_SWAP   = 3'd4,
        KIND_CLEAR  = 3'd5
    } kind_t;

    // result status
    typedef enum logic [STAT_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    // per-cell update operation
    typedef enum logic [2:0] {
        CELL_HOLD     = 3'd0,
        CELL_LOAD_IN  = 3'd1,
        CELL_LOAD_A   = 3'd2,
        CELL_LOAD_B   = 3'd3,
        CELL_SHIFT_UP = 3'd4,
        CELL_SHIFT_DN = 3'd5
    } cell_op_t;

    // control handed to each cell
    typedef struct packed {
        cell_op_t op;
        logic     sel_a;
        logic     sel_b;
    } cell_ctrl_t;

endpackage

/* rtl/indexed_list_insert_remove.sv */
// Top level of the indexed list: request register, row of entry cells, result register.
// Depends on ilir_pkg and ilir_cell.
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | request word: kind, position, position_b, value
//  m_*      | out | m_tvalid/m_tready  | result word: value_out, count_out, status
//
// A request is registered on accept and executed once the result register can take it,
// when all cells shift, load or swap together; the result is registered for the output.
// One request per cycle is sustained while m_tready is high.
// Reads go through two one-hot gated buses across the cell row.
// rst_n clears the count and the valid flags only; entry contents stay undefined.
// A stalled output holds the executed request; s_tready drops once the request
// register is also full.
module indexed_list_insert_remove (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ilir_pkg::IN_DATA_W-1:0]  s_tdata,   // position[4:0], position_b[8:5], value_in[40:9]
    input  logic [ilir_pkg::IN_USER_W-1:0]  s_tuser,   // kind[2:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ilir_pkg::OUT_DATA_W-1:0] m_tdata    // value_out[31:0], count_out[36:32], status[38:37]
);
    import ilir_pkg::*;

    // request register
    logic                     req_valid_reg;
    logic [KIND_W-1:0]        req_kind_reg;
    logic [POS_W-1:0]         req_pos_reg;
    logic [POSB_W-1:0]        req_pos_b_reg;
    logic signed [WORD_W-1:0] req_value_reg;

    // list count
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] out_value_reg;
    logic [CNT_W-1:0]         out_count_reg;
    status_t                  out_status_reg;

    logic                     exec_fire;
    logic                     s_fire;
    logic [CNT_W-1:0]         pos_ext;
    logic [CNT_W-1:0]         pos_b_ext;
    logic                     insert_ok;
    logic                     remove_ok;
    logic                     set_ok;
    logic                     get_ok;
    logic                     swap_ok;
    logic                     clear_ok;
    status_t                  status_c;
    logic signed [WORD_W-1:0] value_c;
    logic [WORD_W-1:0]        bus_a;
    logic [WORD_W-1:0]        bus_b;

    logic [WORD_W-1:0] cell_data [CAPACITY];
    logic [WORD_W-1:0] cell_rd_a [CAPACITY];
    logic [WORD_W-1:0] cell_rd_b [CAPACITY];
    cell_ctrl_t        cell_ctrl [CAPACITY];

    // handshakes
    assign exec_fire = req_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !req_valid_reg || exec_fire;
    assign s_fire    = s_tvalid && s_tready;

    assign pos_ext   = req_pos_reg;
    assign pos_b_ext = CNT_W'(req_pos_b_reg);

    // request decode and range checks
    always_comb
    begin
        insert_ok  = 1'b0;
        remove_ok  = 1'b0;
        set_ok     = 1'b0;
        get_ok     = 1'b0;
        swap_ok    = 1'b0;
        clear_ok   = 1'b0;
        status_c   = STAT_DONE;
        unique case (kind_t'(req_kind_reg))
            KIND_INSERT:
            begin
                if (pos_ext > count_reg)
                    status_c = STAT_RANGE;
                else if (count_reg >= CNT_W'(CAPACITY))
                    status_c = STAT_FULL;
                else
                    insert_ok = 1'b1;
            end
            KIND_REMOVE:
            begin
                if (pos_ext >= count_reg)
                    status_c = STAT_RANGE;
                else
                    remove_ok = 1'b1;
            end
            KIND_SET:
            begin
                if (pos_ext >= count_reg)
                    status_c = STAT_RANGE;
                else
                    set_ok = 1'b1;
            end
            KIND_GET:
            begin
                if (pos_ext >= count_reg)
                    status_c = STAT_RANGE;
                else
                    get_ok = 1'b1;
            end
            KIND_SWAP:
            begin
                if (pos_ext >= count_reg || pos_b_ext >= count_reg)
                    status_c = STAT_RANGE;
                else
                    swap_ok = 1'b1;
            end
            KIND_CLEAR:
                clear_ok = 1'b1;
            default:
                status_c = STAT_DONE;
        endcase
    end

    // result value and new count
    always_comb
    begin
        value_c = (remove_ok || get_ok) ? $signed(bus_a) : '0;
        priority if (insert_ok)
            count_next = count_reg + 1'b1;
        else if (remove_ok)
            count_next = count_reg - 1'b1;
        else if (clear_ok)
            count_next = '0;
        else
            count_next = count_reg;
    end

    // row of entry cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX      = CNT_W'(gi);
            localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(gi + 1);

            logic [WORD_W-1:0] lower_w;
            logic [WORD_W-1:0] upper_w;

            // per-cell control
            always_comb
            begin
                cell_ctrl[gi].sel_a = (IDX == pos_ext);
                cell_ctrl[gi].sel_b = (IDX == pos_b_ext);
                cell_ctrl[gi].op    = CELL_HOLD;
                if (exec_fire)
                begin
                    priority if (insert_ok && IDX == pos_ext)
                        cell_ctrl[gi].op = CELL_LOAD_IN;
                    else if (insert_ok && IDX > pos_ext && IDX <= count_reg)
                        cell_ctrl[gi].op = CELL_SHIFT_UP;
                    else if (remove_ok && IDX >= pos_ext && IDX_NEXT < count_reg)
                        cell_ctrl[gi].op = CELL_SHIFT_DN;
                    else if (set_ok && IDX == pos_ext)
                        cell_ctrl[gi].op = CELL_LOAD_IN;
                    else if (swap_ok && IDX == pos_ext)
                        cell_ctrl[gi].op = CELL_LOAD_B;
                    else if (swap_ok && IDX == pos_b_ext)
                        cell_ctrl[gi].op = CELL_LOAD_A;
                    else
                        cell_ctrl[gi].op = CELL_HOLD;
                end
            end

            // neighbor links, open at both ends of the row
            if (gi == 0)
            begin : g_first
                assign lower_w = '0;
            end
            else
            begin : g_lower
                assign lower_w = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign upper_w = '0;
            end
            else
            begin : g_upper
                assign upper_w = cell_data[gi+1];
            end

            ilir_cell u_cell (
                .clk      (clk),
                .ctrl     (cell_ctrl[gi]),
                .value_in (req_value_reg),
                .swap_a   (bus_a),
                .swap_b   (bus_b),
                .lower    (lower_w),
                .upper    (upper_w),
                .data     (cell_data[gi]),
                .rd_a     (cell_rd_a[gi]),
                .rd_b     (cell_rd_b[gi])
            );
        end
    endgenerate

    // read buses: at most one cell drives each
    always_comb
    begin
        bus_a = '0;
        bus_b = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            bus_a = bus_a | cell_rd_a[i];
            bus_b = bus_b | cell_rd_b[i];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_fire)
                req_valid_reg <= 1'b1;
            else if (exec_fire)
                req_valid_reg <= 1'b0;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_kind_reg  <= s_tuser[KIND_W-1:0];
            req_pos_reg   <= s_tdata[POS_W-1:0];
            req_pos_b_reg <= s_tdata[POS_W+POSB_W-1:POS_W];
            req_value_reg <= $signed(s_tdata[POS_W+POSB_W+WORD_W-1:POS_W+POSB_W]);
        end
        if (exec_fire)
        begin
            out_value_reg  <= value_c;
            out_count_reg  <= count_next;
            out_status_reg <= status_c;
        end
    end

    // output word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (OUT_DATA_W - WORD_W - CNT_W - STAT_W)'(0),
        out_status_reg,
        out_count_reg,
        out_value_reg
    };

    // count never exceeds the row length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    // a full report only comes from a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STAT_FULL |-> out_count_reg == CNT_W'(CAPACITY))
        else $error("full status with list not full");

    // a successful insert grows the list by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && insert_ok |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");

    // the result count matches the stored count
    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_count_reg == count_reg)
        else $error("result count differs from list count");

    // a clear empties the list
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire && clear_ok |=> count_reg == '0)
        else $error("clear left entries");

endmodule

/* rtl/ilir_cell.sv */
// One entry of the list: a word register that can load, shift or swap.
// Depends on ilir_pkg.
module ilir_cell (
    input  logic                        clk,
    input  ilir_pkg::cell_ctrl_t        ctrl,
    input  logic [ilir_pkg::WORD_W-1:0] value_in,
    input  logic [ilir_pkg::WORD_W-1:0] swap_a,
    input  logic [ilir_pkg::WORD_W-1:0] swap_b,
    input  logic [ilir_pkg::WORD_W-1:0] lower,
    input  logic [ilir_pkg::WORD_W-1:0] upper,
    output logic [ilir_pkg::WORD_W-1:0] data,
    output logic [ilir_pkg::WORD_W-1:0] rd_a,
    output logic [ilir_pkg::WORD_W-1:0] rd_b
);
    import ilir_pkg::*;

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;

    // next entry value
    always_comb
    begin
        unique case (ctrl.op)
            CELL_LOAD_IN:  data_next = value_in;
            CELL_LOAD_A:   data_next = swap_a;
            CELL_LOAD_B:   data_next = swap_b;
            CELL_SHIFT_UP: data_next = lower;
            CELL_SHIFT_DN: data_next = upper;
            default:       data_next = data_reg;
        endcase
    end

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // gated read onto the two shared read buses
    assign data = data_reg;
    assign rd_a = ctrl.sel_a ? data_reg : '0;
    assign rd_b = ctrl.sel_b ? data_reg : '0;

endmodule
